// File: design/prfl_pkg.sv
`default_nettype none

package prfl_pkg;

  localparam int TIME_W     = 32;
  localparam int FAULT_W    = 16;
  localparam int OUT_PAGE_W = 16;
  localparam int OUT_IDX_W  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0]  REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_FRAMES = 2'd1;
  localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 5'd16;

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_LOAD  = 2'd1,
    OUT_FAULT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic set_valid;
    logic wr_page;
    logic wr_stamp;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/prfl_cell.sv
`default_nettype none

module prfl_cell #(
  parameter int PAGE_W = 16,
  parameter int IDX_W  = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  prfl_pkg::cell_ctl_t     ctl,
  input  wire                           sel,
  input  wire                           in_range,
  input  wire  [IDX_W-1:0]              my_idx,
  input  wire  [PAGE_W-1:0]             lookup_page,
  input  wire  [prfl_pkg::TIME_W-1:0]   stamp_data,
  input  wire                           r_ok,
  input  wire  [prfl_pkg::TIME_W-1:0]   r_val,
  input  wire  [IDX_W-1:0]              r_idx,
  output logic                          valid,
  output logic [PAGE_W-1:0]             page,
  output logic                          match,
  output logic                          cand_ok,
  output logic [prfl_pkg::TIME_W-1:0]   cand_val,
  output logic [IDX_W-1:0]              cand_idx
);

  logic                          valid_r;
  logic [PAGE_W-1:0]             page_r;
  logic [prfl_pkg::TIME_W-1:0]   stamp_r;
  logic                          cand_ok_r;
  logic [prfl_pkg::TIME_W-1:0]   cand_val_r;
  logic [IDX_W-1:0]              cand_idx_r;
  logic                          take;

  // right side covers higher indexes, so a tie keeps our own candidate
  assign take = r_ok && (!cand_ok_r || (r_val < cand_val_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      cand_ok_r <= 1'b0;
    end else begin
      if (ctl.set_valid && sel) begin
        valid_r <= 1'b1;
      end
      if (ctl.load) begin
        cand_ok_r <= in_range;
      end else if (ctl.reduce && take) begin
        cand_ok_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_page && sel) begin
      page_r <= lookup_page;
    end
    if (ctl.wr_stamp && sel) begin
      stamp_r <= stamp_data;
    end
    if (ctl.load) begin
      cand_val_r <= stamp_r;
      cand_idx_r <= my_idx;
    end else if (ctl.reduce && take) begin
      cand_val_r <= r_val;
      cand_idx_r <= r_idx;
    end
  end

  assign valid    = valid_r;
  assign page     = page_r;
  assign match    = valid_r && in_range && (page_r == lookup_page);
  assign cand_ok  = cand_ok_r;
  assign cand_val = cand_val_r;
  assign cand_idx = cand_idx_r;

endmodule

`default_nettype wire

// File: design/page_replacement_fifo_lru.sv
// Page replacement unit, FIFO or LRU. Each input word is one page reference; each produces
// exactly one result word (hit, load into a free frame, or replacement fault with the evicted
// page and the saturating fault total). Frames live in a row of cells that compare against
// the reference in parallel. A hit, load or FIFO replacement is accepted, then looked up and
// committed. An LRU replacement goes on after the lookup: the cells reduce their last-use
// times pairwise at doubling distances, one level per cycle, and the victim is committed from
// cell 0. One reference is in flight at a time; the next is taken while the previous result
// still waits on out_stall. Configuration (policy_mode, frame_count) is to be written through
// cfg_* only while no reference is in flight; the user must keep to this, the block has no check.
`default_nettype none

module page_replacement_fifo_lru #(
  parameter int FRAMES  = 16,
  parameter int PAGE_W  = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [15:0]                        in_page_number,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [1:0]                         out_outcome,
  output logic [prfl_pkg::OUT_IDX_W-1:0]     out_frame_index,
  output logic [prfl_pkg::OUT_PAGE_W-1:0]    out_evicted_page,
  output logic [prfl_pkg::FAULT_W-1:0]       out_fault_total,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [prfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [prfl_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W  = $clog2(FRAMES + 1);
  localparam int CW     = (CNT_W >= 5) ? CNT_W + 1 : 6;
  localparam int STEPS  = $clog2(FRAMES);
  localparam int SL     = (STEPS > 0) ? STEPS : 1;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int TW     = prfl_pkg::TIME_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_MIN  = 4'b0100,
    S_PICK = 4'b1000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [STEP_W-1:0]                   step_r, step_nxt;
  logic                                policy_r;
  logic [prfl_pkg::CFG_DATA_W-1:0]     fcount_r;
  logic [PAGE_W-1:0]                   page_r;
  logic [TW-1:0]                       clock_r;
  logic [IDX_W-1:0]                    fill_r, oldest_r;
  logic [prfl_pkg::FAULT_W-1:0]        fault_r, fault_nxt;

  logic                                out_valid_r;
  prfl_pkg::outcome_t                  outcome_r;
  logic [prfl_pkg::OUT_IDX_W-1:0]      fidx_r;
  logic [prfl_pkg::OUT_PAGE_W-1:0]     evict_r;
  logic [prfl_pkg::FAULT_W-1:0]        ftot_r;

  logic [FRAMES-1:0]                   valid_w, match_w, cand_ok_w, sel_w, range_w;
  logic [PAGE_W-1:0]                   page_w   [FRAMES];
  logic [TW-1:0]                       cand_val_w [FRAMES];
  logic [IDX_W-1:0]                    cand_idx_w [FRAMES];

  prfl_pkg::cell_ctl_t                 ctl;
  logic [CW-1:0]                       fc_ext, n_use, start, fp_ext, op_ext, idx_plus, idx_ext;
  logic                                hit_any, hi_any, lo_any;
  logic [IDX_W-1:0]                    hit_idx, hi_idx, lo_idx, free_idx, fifo_idx;
  logic                                out_free, commit_look, commit_pick, commit, need_min;
  logic [IDX_W-1:0]                    cmt_idx, nxt_ptr;
  prfl_pkg::outcome_t                  cmt_out;
  logic [PAGE_W-1:0]                   ev_page;
  logic [31:0]                         ev_wide;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // frames in use: zero acts as one, clamped at the built count
  always_comb begin
    fc_ext = CW'(fcount_r);
    if (fc_ext == '0) begin
      n_use = CW'(1);
    end else if (fc_ext > CW'(FRAMES)) begin
      n_use = CW'(FRAMES);
    end else begin
      n_use = fc_ext;
    end
    fp_ext   = CW'(fill_r);
    op_ext   = CW'(oldest_r);
    start    = (fp_ext < n_use) ? fp_ext : '0;
    fifo_idx = (op_ext < n_use) ? oldest_r : '0;
  end

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    hi_any  = 1'b0;
    hi_idx  = '0;
    lo_any  = 1'b0;
    lo_idx  = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (match_w[k]) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(k);
      end
      if (!valid_w[k] && range_w[k]) begin
        lo_any = 1'b1;
        lo_idx = IDX_W'(k);
        if (CW'(k) >= start) begin
          hi_any = 1'b1;
          hi_idx = IDX_W'(k);
        end
      end
    end
    free_idx = hi_any ? hi_idx : lo_idx;
  end

  assign need_min    = !hit_any && !lo_any && (policy_r == prfl_pkg::POLICY_LRU);
  assign commit_look = (state_r == S_LOOK) && !need_min && out_free;
  assign commit_pick = (state_r == S_PICK) && out_free;
  assign commit      = commit_look || commit_pick;

  always_comb begin
    if (state_r == S_PICK) begin
      cmt_idx = cand_idx_w[0];
      cmt_out = prfl_pkg::OUT_FAULT;
    end else if (hit_any) begin
      cmt_idx = hit_idx;
      cmt_out = prfl_pkg::OUT_HIT;
    end else if (lo_any) begin
      cmt_idx = free_idx;
      cmt_out = prfl_pkg::OUT_LOAD;
    end else begin
      cmt_idx = fifo_idx;
      cmt_out = prfl_pkg::OUT_FAULT;
    end
    idx_ext  = CW'(cmt_idx);
    idx_plus = idx_ext + CW'(1);
    nxt_ptr  = (idx_plus >= n_use) ? '0 : IDX_W'(idx_plus);
    ev_page  = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (sel_w[k]) begin
        ev_page = page_w[k];
      end
    end
    ev_wide   = 32'(ev_page);
    fault_nxt = (fault_r != '1) ? fault_r + 1'b1 : fault_r;
  end

  always_comb begin
    ctl.load      = (state_r == S_LOOK);
    ctl.reduce    = (state_r == S_MIN);
    ctl.set_valid = commit && (cmt_out == prfl_pkg::OUT_LOAD);
    ctl.wr_page   = commit && (cmt_out != prfl_pkg::OUT_HIT);
    ctl.wr_stamp  = commit;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (commit_look) begin
          state_nxt = S_IDLE;
        end else if (need_min) begin
          state_nxt = (STEPS > 0) ? S_MIN : S_PICK;
          step_nxt  = '0;
        end
      end
      S_MIN: begin
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_PICK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_PICK: begin
        if (commit_pick) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      policy_r    <= prfl_pkg::POLICY_FIFO;
      fcount_r    <= prfl_pkg::FRAMES_RESET;
      clock_r     <= '0;
      fill_r      <= '0;
      oldest_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prfl_pkg::REG_POLICY: policy_r <= cfg_data[0];
          prfl_pkg::REG_FRAMES: fcount_r <= cfg_data;
          default: ;
        endcase
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        if (clock_r != '1) begin
          clock_r <= clock_r + 1'b1;
        end
        if (cmt_out == prfl_pkg::OUT_FAULT) begin
          fault_r <= fault_nxt;
        end
        if (cmt_out == prfl_pkg::OUT_LOAD) begin
          fill_r <= nxt_ptr;
        end
        if (commit_look && (cmt_out == prfl_pkg::OUT_FAULT)) begin
          oldest_r <= nxt_ptr;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      page_r <= PAGE_W'(in_page_number);
    end
    if (commit) begin
      outcome_r <= cmt_out;
      fidx_r    <= idx_ext[prfl_pkg::OUT_IDX_W-1:0];
      evict_r   <= (cmt_out == prfl_pkg::OUT_FAULT) ? ev_wide[prfl_pkg::OUT_PAGE_W-1:0] : '0;
      ftot_r    <= (cmt_out == prfl_pkg::OUT_FAULT) ? fault_nxt : fault_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_frame_index  = fidx_r;
  assign out_evicted_page = evict_r;
  assign out_fault_total  = ftot_r;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    logic [SL-1:0]    opt_ok;
    logic [TW-1:0]    opt_val [SL];
    logic [IDX_W-1:0] opt_idx [SL];
    logic             r_ok;
    logic [TW-1:0]    r_val;
    logic [IDX_W-1:0] r_idx;

    // partner at distance 2^step
    for (genvar j = 0; j < SL; j++) begin : g_opt
      if ((STEPS > 0) && (k + (1 << j) < FRAMES)) begin : g_has
        assign opt_ok[j]  = cand_ok_w[k + (1 << j)];
        assign opt_val[j] = cand_val_w[k + (1 << j)];
        assign opt_idx[j] = cand_idx_w[k + (1 << j)];
      end else begin : g_none
        assign opt_ok[j]  = 1'b0;
        assign opt_val[j] = '0;
        assign opt_idx[j] = '0;
      end
    end

    always_comb begin
      r_ok  = 1'b0;
      r_val = '0;
      r_idx = '0;
      for (int j = 0; j < SL; j++) begin
        if (step_r == STEP_W'(j)) begin
          r_ok  = opt_ok[j];
          r_val = opt_val[j];
          r_idx = opt_idx[j];
        end
      end
    end

    assign range_w[k] = (CW'(k) < n_use);
    assign sel_w[k]   = (cmt_idx == IDX_W'(k));

    prfl_cell #(
      .PAGE_W (PAGE_W),
      .IDX_W  (IDX_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .sel         (sel_w[k]),
      .in_range    (range_w[k]),
      .my_idx      (IDX_W'(k)),
      .lookup_page (page_r),
      .stamp_data  (clock_r),
      .r_ok        (r_ok),
      .r_val       (r_val),
      .r_idx       (r_idx),
      .valid       (valid_w[k]),
      .page        (page_w[k]),
      .match       (match_w[k]),
      .cand_ok     (cand_ok_w[k]),
      .cand_val    (cand_val_w[k]),
      .cand_idx    (cand_idx_w[k])
    );
  end

endmodule

`default_nettype wire
